[rtl/scs_pkg.sv]
// Package for the stable counting sort unit: port layout constants, default
// parameter values and the microcode types and program of the sort sequencer.
// Used by every module of the block; depends on nothing.
package scs_pkg;

  // Default parameter values.
  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int KEY_BITS_DEF     = 8;
  localparam int VALUE_BITS_DEF   = 32;

  // Port field widths.
  localparam int KEY_W     = 8;
  localparam int PAYLOAD_W = 32;
  localparam int INDEX_W   = 10;

  // Input tdata: sort_key, payload, read_index from the lowest bit up.
  localparam int IN_KEY_LSB   = 0;
  localparam int IN_PAY_LSB   = IN_KEY_LSB + KEY_W;
  localparam int IN_IDX_LSB   = IN_PAY_LSB + PAYLOAD_W;
  localparam int IN_TDATA_W   = ((IN_IDX_LSB + INDEX_W + 7) / 8) * 8;

  // Output tdata: sorted_payload, sorted_key from the lowest bit up.
  localparam int OUT_PAY_LSB  = 0;
  localparam int OUT_KEY_LSB  = OUT_PAY_LSB + PAYLOAD_W;
  localparam int OUT_TDATA_W  = ((OUT_KEY_LSB + KEY_W + 7) / 8) * 8;

  // Command codes carried in in_tuser.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Microprogram addresses.
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_CLR      = 4'd1;
  localparam logic [PC_W-1:0] PC_CNT_INIT = 4'd2;
  localparam logic [PC_W-1:0] PC_CNT_RD   = 4'd3;
  localparam logic [PC_W-1:0] PC_CNT_KEY  = 4'd4;
  localparam logic [PC_W-1:0] PC_CNT_WR   = 4'd5;
  localparam logic [PC_W-1:0] PC_PFX_INIT = 4'd6;
  localparam logic [PC_W-1:0] PC_PFX_RD   = 4'd7;
  localparam logic [PC_W-1:0] PC_PFX_WR   = 4'd8;
  localparam logic [PC_W-1:0] PC_PLC_INIT = 4'd9;
  localparam logic [PC_W-1:0] PC_PLC_DEC  = 4'd10;
  localparam logic [PC_W-1:0] PC_PLC_RD   = 4'd11;
  localparam logic [PC_W-1:0] PC_PLC_KEY  = 4'd12;
  localparam logic [PC_W-1:0] PC_PLC_WR   = 4'd13;
  localparam logic [PC_W-1:0] PC_DONE     = 4'd14;

  // Datapath operation of one step.
  typedef enum logic [3:0] {
    UOP_NONE,
    UOP_CLR,      // bucket[idx] = 0
    UOP_SRC_RD,   // read source[idx]
    UOP_KEY,      // latch source entry, read bucket[key]
    UOP_INC_WR,   // bucket[key] = bucket + 1
    UOP_ACC_CLR,  // running sum = 0
    UOP_BKT_RD,   // read bucket[idx]
    UOP_PFX_WR,   // bucket[idx] = sum + bucket, sum updated
    UOP_PLC_WR,   // bucket[key] = bucket - 1, sorted[bucket - 1] = entry
    UOP_DONE      // mark the set sorted
  } uop_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLEAR,
    IDX_INC,
    IDX_DEC,
    IDX_LOAD_CNT
  } idx_op_t;

  // A step jumps to its target when its condition holds, else falls through.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_IDX_NE_LASTB,
    COND_IDX_EQ_CNT,
    COND_IDX_EQ_NB,
    COND_IDX_ZERO
  } cond_t;

  typedef struct packed {
    uop_t            uop;
    idx_op_t         idx_op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // Index flags from the datapath that the jump conditions test.
  typedef struct packed {
    logic idx_zero;
    logic idx_eq_cnt;
    logic idx_eq_nb;
    logic idx_last_bkt;
  } dp_status_t;

  function automatic ctrl_word_t cw(input uop_t u, input idx_op_t i, input cond_t c,
                                    input logic [PC_W-1:0] t);
    ctrl_word_t w;
    w.uop    = u;
    w.idx_op = i;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // The sort program: clear buckets, count keys, prefix sums, back-to-front placement.
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      PC_IDLE:     w = cw(UOP_NONE,    IDX_CLEAR,    COND_NO_START,     PC_IDLE);
      PC_CLR:      w = cw(UOP_CLR,     IDX_INC,      COND_IDX_NE_LASTB, PC_CLR);
      PC_CNT_INIT: w = cw(UOP_NONE,    IDX_CLEAR,    COND_NEVER,        PC_IDLE);
      PC_CNT_RD:   w = cw(UOP_SRC_RD,  IDX_HOLD,     COND_IDX_EQ_CNT,   PC_PFX_INIT);
      PC_CNT_KEY:  w = cw(UOP_KEY,     IDX_HOLD,     COND_NEVER,        PC_IDLE);
      PC_CNT_WR:   w = cw(UOP_INC_WR,  IDX_INC,      COND_ALWAYS,       PC_CNT_RD);
      PC_PFX_INIT: w = cw(UOP_ACC_CLR, IDX_CLEAR,    COND_NEVER,        PC_IDLE);
      PC_PFX_RD:   w = cw(UOP_BKT_RD,  IDX_HOLD,     COND_IDX_EQ_NB,    PC_PLC_INIT);
      PC_PFX_WR:   w = cw(UOP_PFX_WR,  IDX_INC,      COND_ALWAYS,       PC_PFX_RD);
      PC_PLC_INIT: w = cw(UOP_NONE,    IDX_LOAD_CNT, COND_NEVER,        PC_IDLE);
      PC_PLC_DEC:  w = cw(UOP_NONE,    IDX_DEC,      COND_IDX_ZERO,     PC_DONE);
      PC_PLC_RD:   w = cw(UOP_SRC_RD,  IDX_HOLD,     COND_NEVER,        PC_IDLE);
      PC_PLC_KEY:  w = cw(UOP_KEY,     IDX_HOLD,     COND_NEVER,        PC_IDLE);
      PC_PLC_WR:   w = cw(UOP_PLC_WR,  IDX_HOLD,     COND_ALWAYS,       PC_PLC_DEC);
      PC_DONE:     w = cw(UOP_DONE,    IDX_HOLD,     COND_ALWAYS,       PC_IDLE);
      default:     w = cw(UOP_NONE,    IDX_CLEAR,    COND_ALWAYS,       PC_IDLE);
    endcase
    return w;
  endfunction

endpackage

[rtl/stable_counting_sort_unit.sv]
// Top level of the stable counting sort unit: stream handshakes, read result
// register and the sequencer and datapath instances. Depends on scs_pkg,
// scs_useq and scs_datapath.
//
// Usage: each input transfer is a command in in_tuser. A load (CMD_LOAD) stores
// one element (key and payload); in_tlast marks the last element of a set and
// starts the sort. A read (CMD_READ) returns one result transfer with the
// element at read_index of the sorted set and in_range in out_tuser; an index
// at or beyond the element count, or a set not yet sorted, returns zeros with
// in_range low. A load after a sorted set starts a new set; loads beyond
// MAX_ELEMENTS are dropped but their last mark still starts the sort.
// Throughput: loads are taken one per cycle while no read is pending and no
// result is held back. A read passes the registered sorted memory read, then
// the result register. After the last load in_tready stays low for the sort
// program: bucket clear, key count (source read, key, increment per element),
// prefix sums (bucket read, write per bucket) and placement (index decrement,
// source read, key, write per element), all through the single bucket memory.
// When out_tready is low the held result stays and no further input is taken.
// Reset empties the set and the result channel.
module stable_counting_sort_unit #(
  parameter int MAX_ELEMENTS = scs_pkg::MAX_ELEMENTS_DEF,
  parameter int KEY_BITS     = scs_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS   = scs_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // sort_key [7:0], payload [39:8], read_index [49:40], zero fill above
  input  logic [scs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,   // is_last
  input  logic                            in_tuser,   // command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // sorted_payload [31:0], sorted_key [39:32]
  output logic [scs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser   // in_range
);

  scs_pkg::ctrl_word_t ctrl;
  scs_pkg::dp_status_t status;
  logic                idle;
  logic                in_xfer;
  logic                ld_en;
  logic                rd_en;
  logic                start;
  logic                rd_pend_r;
  logic                out_tvalid_r;
  logic [scs_pkg::PAYLOAD_W-1:0] rd_payload;
  logic [scs_pkg::KEY_W-1:0]     rd_key;
  logic                          rd_hit;
  logic [scs_pkg::PAYLOAD_W-1:0] out_pay_r;
  logic [scs_pkg::KEY_W-1:0]     out_key_r;
  logic                          out_hit_r;

  assign in_tready = idle && !rd_pend_r && (!out_tvalid_r || out_tready);
  assign in_xfer   = in_tvalid && in_tready;
  assign ld_en     = in_xfer && (in_tuser == scs_pkg::CMD_LOAD);
  assign rd_en     = in_xfer && (in_tuser == scs_pkg::CMD_READ);
  assign start     = ld_en && in_tlast;

  scs_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .idle   (idle)
  );

  scs_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .KEY_BITS     (KEY_BITS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .ld_en      (ld_en),
    .ld_key     (in_tdata[scs_pkg::IN_KEY_LSB +: scs_pkg::KEY_W]),
    .ld_payload (in_tdata[scs_pkg::IN_PAY_LSB +: scs_pkg::PAYLOAD_W]),
    .rd_en      (rd_en),
    .rd_index   (in_tdata[scs_pkg::IN_IDX_LSB +: scs_pkg::INDEX_W]),
    .status     (status),
    .rd_payload (rd_payload),
    .rd_key     (rd_key),
    .rd_hit     (rd_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      rd_pend_r <= rd_en;
      if (rd_pend_r) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_pay_r <= rd_payload;
      out_key_r <= rd_key;
      out_hit_r <= rd_hit;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = scs_pkg::OUT_TDATA_W'({out_key_r, out_pay_r});
  assign out_tuser  = out_hit_r;

endmodule

[rtl/scs_useq.sv]
// Microcode sequencer of the stable counting sort unit: step counter, program
// table lookup and conditional jumps. Depends on scs_pkg.
module scs_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  scs_pkg::dp_status_t status,
  output scs_pkg::ctrl_word_t ctrl,
  output logic                idle
);

  logic [scs_pkg::PC_W-1:0] pc_r;
  logic [scs_pkg::PC_W-1:0] pc_nxt;
  logic                     take;

  assign ctrl = scs_pkg::ucode(pc_r);
  assign idle = (pc_r == scs_pkg::PC_IDLE);

  always_comb begin
    case (ctrl.cond)
      scs_pkg::COND_NEVER:        take = 1'b0;
      scs_pkg::COND_ALWAYS:       take = 1'b1;
      scs_pkg::COND_NO_START:     take = !start;
      scs_pkg::COND_IDX_NE_LASTB: take = !status.idx_last_bkt;
      scs_pkg::COND_IDX_EQ_CNT:   take = status.idx_eq_cnt;
      scs_pkg::COND_IDX_EQ_NB:    take = status.idx_eq_nb;
      scs_pkg::COND_IDX_ZERO:     take = status.idx_zero;
      default:                    take = 1'b1;
    endcase
    pc_nxt = take ? ctrl.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= scs_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[rtl/scs_datapath.sv]
// Datapath of the stable counting sort unit: source, bucket and sorted memories,
// the index counter and running sum driven by the microcode word. Depends on scs_pkg.
module scs_datapath #(
  parameter int MAX_ELEMENTS = scs_pkg::MAX_ELEMENTS_DEF,
  parameter int KEY_BITS     = scs_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS   = scs_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scs_pkg::ctrl_word_t           ctrl,
  input  logic                          ld_en,
  input  logic [scs_pkg::KEY_W-1:0]     ld_key,
  input  logic [scs_pkg::PAYLOAD_W-1:0] ld_payload,
  input  logic                          rd_en,
  input  logic [scs_pkg::INDEX_W-1:0]   rd_index,
  output scs_pkg::dp_status_t           status,
  output logic [scs_pkg::PAYLOAD_W-1:0] rd_payload,
  output logic [scs_pkg::KEY_W-1:0]     rd_key,
  output logic                          rd_hit
);

  localparam int NB   = 1 << KEY_BITS;
  localparam int AW   = $clog2(MAX_ELEMENTS);
  localparam int CW   = $clog2(MAX_ELEMENTS + 1);
  localparam int IW   = (KEY_BITS + 1 > CW) ? KEY_BITS + 1 : CW;
  localparam int EW   = KEY_BITS + VALUE_BITS;
  localparam int KXW  = (KEY_BITS > scs_pkg::KEY_W) ? KEY_BITS : scs_pkg::KEY_W;
  localparam int VXW  = (VALUE_BITS > scs_pkg::PAYLOAD_W) ? VALUE_BITS : scs_pkg::PAYLOAD_W;
  localparam int CMPW = (CW > scs_pkg::INDEX_W) ? CW : scs_pkg::INDEX_W;
  localparam int IXW  = (AW > scs_pkg::INDEX_W) ? AW : scs_pkg::INDEX_W;

  logic [EW-1:0] src_mem [MAX_ELEMENTS];
  logic [EW-1:0] srt_mem [MAX_ELEMENTS];
  logic [CW-1:0] bkt_mem [NB];

  logic [CW-1:0]       count_r;
  logic                sorted_r;
  logic [IW-1:0]       idx_r;
  logic [IW-1:0]       idx_nxt;
  logic [CW-1:0]       acc_r;
  logic [KEY_BITS-1:0] key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [EW-1:0]       src_rdata_r;
  logic [CW-1:0]       bkt_rdata_r;
  logic [EW-1:0]       srt_rdata_r;
  logic                hit_r;

  logic [KXW-1:0]        ld_key_x;
  logic [VXW-1:0]        ld_val_x;
  logic [EW-1:0]         ld_entry;
  logic                  ld_store;
  logic [AW-1:0]         ld_addr;
  logic [KEY_BITS-1:0]   bkt_raddr;
  logic                  bkt_we;
  logic [KEY_BITS-1:0]   bkt_waddr;
  logic [CW-1:0]         bkt_wdata;
  logic [CW-1:0]         pfx_sum;
  logic [CW-1:0]         slot;
  logic [CMPW-1:0]       rd_idx_cmp;
  logic [IXW-1:0]        rd_idx_x;
  logic [KXW-1:0]        out_key_x;
  logic [VXW-1:0]        out_val_x;

  // Narrow or widen the port fields to the stored widths.
  assign ld_key_x = KXW'(ld_key);
  assign ld_val_x = VXW'(ld_payload);
  assign ld_entry = {ld_key_x[KEY_BITS-1:0], ld_val_x[VALUE_BITS-1:0]};

  // A load into a sorted set starts a new set at entry zero.
  assign ld_store = ld_en && (sorted_r || (count_r < CW'(MAX_ELEMENTS)));
  assign ld_addr  = sorted_r ? '0 : count_r[AW-1:0];

  assign status.idx_zero     = (idx_r == '0);
  assign status.idx_eq_cnt   = (idx_r == IW'(count_r));
  assign status.idx_eq_nb    = (idx_r == IW'(NB));
  assign status.idx_last_bkt = (idx_r == IW'(NB - 1));

  assign pfx_sum   = acc_r + bkt_rdata_r;
  assign slot      = bkt_rdata_r - CW'(1);
  assign bkt_raddr = (ctrl.uop == scs_pkg::UOP_KEY) ? src_rdata_r[EW-1:VALUE_BITS]
                                                     : idx_r[KEY_BITS-1:0];

  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = idx_r[KEY_BITS-1:0];
    bkt_wdata = '0;
    case (ctrl.uop)
      scs_pkg::UOP_CLR: begin
        bkt_we = 1'b1;
      end
      scs_pkg::UOP_INC_WR: begin
        bkt_we    = 1'b1;
        bkt_waddr = key_r;
        bkt_wdata = bkt_rdata_r + CW'(1);
      end
      scs_pkg::UOP_PFX_WR: begin
        bkt_we    = 1'b1;
        bkt_wdata = pfx_sum;
      end
      scs_pkg::UOP_PLC_WR: begin
        bkt_we    = 1'b1;
        bkt_waddr = key_r;
        bkt_wdata = slot;
      end
      default: begin
        bkt_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (ctrl.idx_op)
      scs_pkg::IDX_CLEAR:    idx_nxt = '0;
      scs_pkg::IDX_INC:      idx_nxt = idx_r + 1'b1;
      scs_pkg::IDX_DEC:      idx_nxt = idx_r - 1'b1;
      scs_pkg::IDX_LOAD_CNT: idx_nxt = IW'(count_r);
      default:               idx_nxt = idx_r;
    endcase
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (ld_store) begin
      src_mem[ld_addr] <= ld_entry;
    end
    if (ctrl.uop == scs_pkg::UOP_SRC_RD) begin
      src_rdata_r <= src_mem[idx_r[AW-1:0]];
    end
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_rdata_r <= bkt_mem[bkt_raddr];
    if (ctrl.uop == scs_pkg::UOP_PLC_WR) begin
      srt_mem[slot[AW-1:0]] <= {key_r, val_r};
    end
    if (rd_en) begin
      srt_rdata_r <= srt_mem[rd_idx_x[AW-1:0]];
    end
  end

  assign rd_idx_cmp = CMPW'(rd_index);
  assign rd_idx_x   = IXW'(rd_index);

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctrl.uop == scs_pkg::UOP_KEY) begin
      key_r <= src_rdata_r[EW-1:VALUE_BITS];
      val_r <= src_rdata_r[VALUE_BITS-1:0];
    end
    if (ctrl.uop == scs_pkg::UOP_ACC_CLR) begin
      acc_r <= '0;
    end else if (ctrl.uop == scs_pkg::UOP_PFX_WR) begin
      acc_r <= pfx_sum;
    end
    if (rd_en) begin
      hit_r <= sorted_r && (rd_idx_cmp < CMPW'(count_r));
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sorted_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (ld_en && sorted_r) begin
        count_r  <= CW'(1);
        sorted_r <= 1'b0;
      end else if (ld_store) begin
        count_r <= count_r + 1'b1;
      end else if (ctrl.uop == scs_pkg::UOP_DONE) begin
        sorted_r <= 1'b1;
      end
    end
  end

  assign out_key_x  = KXW'(srt_rdata_r[EW-1:VALUE_BITS]);
  assign out_val_x  = VXW'(srt_rdata_r[VALUE_BITS-1:0]);
  assign rd_hit     = hit_r;
  assign rd_key     = hit_r ? out_key_x[scs_pkg::KEY_W-1:0] : '0;
  assign rd_payload = hit_r ? out_val_x[scs_pkg::PAYLOAD_W-1:0] : '0;

endmodule
